FILE: hw/rtl/lea_pkg.sv
// types, constants and round functions shared by the lea cipher engine
package lea_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned RkPerRnd = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegKey01  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey23  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey45  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey67  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeyLen = 3'd4;

  // key size codes
  localparam logic [1:0] Mode128 = 2'd0;
  localparam logic [1:0] Mode192 = 2'd1;
  localparam logic [1:0] Mode256 = 2'd2;

  localparam int unsigned Rounds128 = 24;
  localparam int unsigned Rounds192 = 28;
  localparam int unsigned Rounds256 = 32;

  localparam logic [7:0][WordW-1:0] Delta = {
    32'he5c40957, 32'he04ef22a, 32'hc785da0a, 32'h715ea49e,
    32'h78df30ec, 32'h79e27c8a, 32'h44626b02, 32'hc3efe9db
  };

  typedef logic [RkPerRnd-1:0][WordW-1:0] rk_round_t;
  typedef logic [3:0][WordW-1:0] state_t;

  typedef struct packed {
    logic             operation;
    logic [WordW-1:0] block_word_0;
    logic [WordW-1:0] block_word_1;
    logic [WordW-1:0] block_word_2;
    logic [WordW-1:0] block_word_3;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] out_word_0;
    logic [WordW-1:0] out_word_1;
    logic [WordW-1:0] out_word_2;
    logic [WordW-1:0] out_word_3;
  } out_t;

  function automatic logic [WordW-1:0] bswap(input logic [WordW-1:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [WordW-1:0] rol_var(input logic [WordW-1:0] x,
                                               input logic [4:0] r);
    logic [2*WordW-1:0] d;
    d = {x, x} << r;
    return d[2*WordW-1:WordW];
  endfunction

  // one encryption round
  function automatic state_t enc_round(input state_t t, input rk_round_t rk);
    state_t n;
    logic [WordW-1:0] s0, s1, s2;
    s0 = (t[0] ^ rk[0]) + (t[1] ^ rk[1]);
    s1 = (t[1] ^ rk[2]) + (t[2] ^ rk[3]);
    s2 = (t[2] ^ rk[4]) + (t[3] ^ rk[5]);
    n[0] = {s0[22:0], s0[31:23]};
    n[1] = {s1[4:0], s1[31:5]};
    n[2] = {s2[2:0], s2[31:3]};
    n[3] = t[0];
    return n;
  endfunction

  // one decryption round
  function automatic state_t dec_round(input state_t t, input rk_round_t rk);
    state_t n;
    n[0] = t[3];
    n[1] = ({t[0][8:0], t[0][31:9]} - (n[0] ^ rk[0])) ^ rk[1];
    n[2] = ({t[1][26:0], t[1][31:27]} - (n[1] ^ rk[2])) ^ rk[3];
    n[3] = ({t[2][28:0], t[2][31:29]} - (n[2] ^ rk[4])) ^ rk[5];
    return n;
  endfunction

endpackage

FILE: hw/rtl/lea_key_sched.sv
// key registers and key schedule sequencer, one round of keys per cycle
module lea_key_sched #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lea_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [lea_pkg::CfgW-1:0]             cfg_data_i,
  output logic                                 keys_ready_o,
  output logic [1:0]                           mode_o,
  output lea_pkg::rk_round_t                   rk_o [MAX_ROUNDS]
);
  import lea_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROUNDS);
  localparam int unsigned N0 = (Rounds128 > MAX_ROUNDS) ? MAX_ROUNDS : Rounds128;
  localparam int unsigned N1 = (Rounds192 > MAX_ROUNDS) ? MAX_ROUNDS : Rounds192;
  localparam int unsigned N2 = (Rounds256 > MAX_ROUNDS) ? MAX_ROUNDS : Rounds256;

  logic [3:0][CfgW-1:0] kw_q;
  logic [1:0]           klen_q;
  logic                 ready_q, run_q;
  logic [RW:0]          rnd_q;
  logic [2:0]           d6_q, w8_q;
  logic [7:0][WordW-1:0] t_q, t_d, t_init;
  rk_round_t            rk_new;
  rk_round_t            rk_q [MAX_ROUNDS];
  logic [1:0]           mode;
  logic [RW:0]          nr;
  logic                 cfg_hit;

  // saturate key size and pick round count
  always_comb begin
    mode = (klen_q == 2'd3) ? Mode256 : klen_q;
    case (mode)
      Mode128: nr = (RW+1)'(N0);
      Mode192: nr = (RW+1)'(N1);
      default: nr = (RW+1)'(N2);
    endcase
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i inside {RegKey01, RegKey23, RegKey45,
                                                  RegKey67, RegKeyLen});

  // byte-swapped key words at schedule start
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      t_init[k] = bswap(kw_q[k/2][(k%2)*WordW +: WordW]);
    end
  end

  // one schedule round
  always_comb begin
    logic [2:0] w;
    t_d = t_q;
    rk_new = '0;
    w = '0;
    case (mode)
      Mode128: begin
        for (int k = 0; k < 4; k++) begin
          t_d[k] = t_q[k] + rol_var(Delta[rnd_q[1:0]], 5'(rnd_q + (RW+1)'(k)));
        end
        t_d[0] = {t_d[0][30:0], t_d[0][31]};
        t_d[1] = {t_d[1][28:0], t_d[1][31:29]};
        t_d[2] = {t_d[2][25:0], t_d[2][31:26]};
        t_d[3] = {t_d[3][20:0], t_d[3][31:21]};
        rk_new = {t_d[1], t_d[3], t_d[1], t_d[2], t_d[1], t_d[0]};
      end
      Mode192: begin
        for (int k = 0; k < 6; k++) begin
          t_d[k] = t_q[k] + rol_var(Delta[d6_q], 5'(rnd_q + (RW+1)'(k)));
        end
        t_d[0] = {t_d[0][30:0], t_d[0][31]};
        t_d[1] = {t_d[1][28:0], t_d[1][31:29]};
        t_d[2] = {t_d[2][25:0], t_d[2][31:26]};
        t_d[3] = {t_d[3][20:0], t_d[3][31:21]};
        t_d[4] = {t_d[4][18:0], t_d[4][31:19]};
        t_d[5] = {t_d[5][14:0], t_d[5][31:15]};
        for (int k = 0; k < 6; k++) begin
          rk_new[k] = t_d[k];
        end
      end
      default: begin
        for (int k = 0; k < 6; k++) begin
          logic [WordW-1:0] s;
          w = w8_q + 3'(k);
          s = t_q[w] + rol_var(Delta[rnd_q[2:0]], 5'(rnd_q + (RW+1)'(k)));
          case (k)
            0:       s = {s[30:0], s[31]};
            1:       s = {s[28:0], s[31:29]};
            2:       s = {s[25:0], s[31:26]};
            3:       s = {s[20:0], s[31:21]};
            4:       s = {s[18:0], s[31:19]};
            default: s = {s[14:0], s[31:15]};
          endcase
          t_d[w] = s;
          rk_new[k] = s;
        end
      end
    endcase
  end

  // configuration registers and sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q    <= '0;
      klen_q  <= '0;
      ready_q <= 1'b0;
      run_q   <= 1'b0;
      rnd_q   <= '0;
      d6_q    <= '0;
      w8_q    <= '0;
      t_q     <= '0;
    end else if (cfg_hit) begin
      if (cfg_idx_i == RegKeyLen) begin
        klen_q <= cfg_data_i[1:0];
      end else begin
        kw_q[cfg_idx_i[1:0]] <= cfg_data_i;
      end
      ready_q <= 1'b0;
      run_q   <= 1'b0;
    end else if (!ready_q && !run_q) begin
      t_q   <= t_init;
      rnd_q <= '0;
      d6_q  <= '0;
      w8_q  <= '0;
      run_q <= 1'b1;
    end else if (run_q) begin
      t_q   <= t_d;
      rnd_q <= rnd_q + 1'b1;
      d6_q  <= (d6_q == 3'd5) ? 3'd0 : d6_q + 3'd1;
      w8_q  <= w8_q + 3'd6;
      if (rnd_q == nr - 1'b1) begin
        run_q   <= 1'b0;
        ready_q <= 1'b1;
      end
    end
  end

  // round key storage, one round written per cycle
  always_ff @(posedge clk_i) begin
    if (run_q && !cfg_hit) begin
      rk_q[rnd_q[RW-1:0]] <= rk_new;
    end
  end

  assign rk_o         = rk_q;
  assign keys_ready_o = ready_q;
  assign mode_o       = mode;

endmodule

FILE: hw/rtl/lea_block_cipher_top.sv
// lea block cipher engine top level: one pipeline stage per round
//
//  channel | direction | signals                              | transfer when
//  in      | input     | in_valid_i in_ready_o in_data_i      | valid and ready high
//  out     | output    | out_valid_o out_ready_i out_data_o   | valid and ready high
//  cfg     | input     | cfg_we_i cfg_idx_i cfg_data_i        | write enable high
//
// a block is registered at input, then after each round stage up to the output; one block may
// enter every cycle while the keys are ready and the output is not stalled, set by the
// unrolled round pipeline with a stage per round. after reset and after every key
// register write the schedule runs again, during which no input is taken.
// a stalled output freezes the whole pipeline; nothing is lost or repeated.
module lea_block_cipher_top #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lea_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lea_pkg::out_t               out_data_o,
  input  logic                        cfg_we_i,
  input  logic [lea_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lea_pkg::CfgW-1:0]    cfg_data_i
);
  import lea_pkg::*;

  localparam int unsigned N0 = (Rounds128 > MAX_ROUNDS) ? MAX_ROUNDS : Rounds128;
  localparam int unsigned N1 = (Rounds192 > MAX_ROUNDS) ? MAX_ROUNDS : Rounds192;
  localparam int unsigned N2 = (Rounds256 > MAX_ROUNDS) ? MAX_ROUNDS : Rounds256;

  logic       keys_ready;
  logic [1:0] mode;
  rk_round_t  rk [MAX_ROUNDS];
  logic       adv;

  logic       v_q   [MAX_ROUNDS+1];
  logic       dec_q [MAX_ROUNDS+1];
  state_t     st_q  [MAX_ROUNDS+1];
  state_t     st_d  [MAX_ROUNDS];

  lea_key_sched #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .keys_ready_o (keys_ready),
    .mode_o       (mode),
    .rk_o         (rk)
  );

  // whole pipeline moves when the output register is free or drained
  assign adv        = !v_q[MAX_ROUNDS] || out_ready_i;
  assign in_ready_o = keys_ready && adv;

  // round stages
  for (genvar s = 0; s < MAX_ROUNDS; s++) begin : g_rnd
    localparam int unsigned D0 = (s < N0) ? N0 - 1 - s : 0;
    localparam int unsigned D1 = (s < N1) ? N1 - 1 - s : 0;
    localparam int unsigned D2 = (s < N2) ? N2 - 1 - s : 0;
    localparam logic A0 = (s < N0);
    localparam logic A1 = (s < N1);
    localparam logic A2 = (s < N2);
    rk_round_t dk;
    logic      act;

    always_comb begin
      case (mode)
        Mode128: begin
          dk  = rk[D0];
          act = A0;
        end
        Mode192: begin
          dk  = rk[D1];
          act = A1;
        end
        default: begin
          dk  = rk[D2];
          act = A2;
        end
      endcase
      if (!act) begin
        st_d[s] = st_q[s];
      end else if (dec_q[s]) begin
        st_d[s] = dec_round(st_q[s], dk);
      end else begin
        st_d[s] = enc_round(st_q[s], rk[s]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= MAX_ROUNDS; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= in_valid_i && keys_ready;
      for (int s = 0; s < MAX_ROUNDS; s++) begin
        v_q[s+1] <= v_q[s];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dec_q[0] <= in_data_i.operation;
      st_q[0]  <= {bswap(in_data_i.block_word_3), bswap(in_data_i.block_word_2),
                   bswap(in_data_i.block_word_1), bswap(in_data_i.block_word_0)};
      for (int s = 0; s < MAX_ROUNDS; s++) begin
        dec_q[s+1] <= dec_q[s];
        st_q[s+1]  <= st_d[s];
      end
    end
  end

  assign out_valid_o           = v_q[MAX_ROUNDS];
  assign out_data_o.out_word_0 = bswap(st_q[MAX_ROUNDS][0]);
  assign out_data_o.out_word_1 = bswap(st_q[MAX_ROUNDS][1]);
  assign out_data_o.out_word_2 = bswap(st_q[MAX_ROUNDS][2]);
  assign out_data_o.out_word_3 = bswap(st_q[MAX_ROUNDS][3]);

endmodule

FILE: verif/lea_block_cipher_top_tb.sv
// self-checking testbench for the lea block cipher engine top level
module lea_block_cipher_top_tb;
  import lea_pkg::*;

  localparam int unsigned MaxRounds = 32;
  localparam int unsigned RkDepth   = MaxRounds * 6;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseLen  = 125;
  localparam logic        OpEnc     = 1'b0;
  localparam logic        OpDec     = 1'b1;
  localparam logic [1:0]  ModeSat   = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;

  // local copy of the engine state
  logic [63:0]       key_reg [4];
  logic [1:0]        key_len;
  logic              sched_done;
  logic [WordW-1:0]  expanded_keys [RkDepth];
  logic [WordW-1:0]  sched_words [8];

  out_t        pending_blocks [$];
  int unsigned errors = 0;
  int unsigned blocks_in = 0;
  int unsigned blocks_out = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  bit          calm = 1'b0;

  lea_block_cipher_top #(.MAX_ROUNDS(MaxRounds)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("timeout with %0d blocks outstanding", pending_blocks.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    int unsigned s;
    s = r % 32;
    return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic int unsigned eff_mode();
    return (key_len >= 2) ? 2 : key_len;
  endfunction

  function automatic int unsigned num_rounds();
    int unsigned n;
    n = (eff_mode() == 0) ? 24 : ((eff_mode() == 1) ? 28 : 32);
    return (n > MaxRounds) ? MaxRounds : n;
  endfunction

  // key expansion into the round-key store
  task automatic expand_key();
    int unsigned shifts [6] = '{1, 3, 6, 11, 13, 17};
    int unsigned m, nr, w;
    m = eff_mode();
    nr = num_rounds();
    for (int k = 0; k < 8; k++) begin
      sched_words[k] = swap_bytes(key_reg[k/2][(k%2)*32 +: 32]);
    end
    for (int unsigned i = 0; i < nr; i++) begin
      if (m == 0) begin
        for (int unsigned k = 0; k < 4; k++) begin
          sched_words[k] = rotl(sched_words[k] + rotl(Delta[i%4], i + k), shifts[k]);
        end
        expanded_keys[i*6+0] = sched_words[0];
        expanded_keys[i*6+1] = sched_words[1];
        expanded_keys[i*6+2] = sched_words[2];
        expanded_keys[i*6+3] = sched_words[1];
        expanded_keys[i*6+4] = sched_words[3];
        expanded_keys[i*6+5] = sched_words[1];
      end else if (m == 1) begin
        for (int unsigned k = 0; k < 6; k++) begin
          sched_words[k] = rotl(sched_words[k] + rotl(Delta[i%6], i + k), shifts[k]);
          expanded_keys[i*6+k] = sched_words[k];
        end
      end else begin
        for (int unsigned k = 0; k < 6; k++) begin
          w = (i * 6 + k) % 8;
          sched_words[w] = rotl(sched_words[w] + rotl(Delta[i%8], i + k), shifts[k]);
          expanded_keys[i*6+k] = sched_words[w];
        end
      end
    end
    sched_done = 1'b1;
  endtask

  // expected result of one block
  task automatic cipher_block(input in_t it, output out_t res);
    logic [31:0] t [4];
    logic [31:0] a, b, c;
    int unsigned nr, j;
    if (!sched_done) expand_key();
    nr = num_rounds();
    t[0] = swap_bytes(it.block_word_0);
    t[1] = swap_bytes(it.block_word_1);
    t[2] = swap_bytes(it.block_word_2);
    t[3] = swap_bytes(it.block_word_3);
    for (int unsigned i = 0; i < nr; i++) begin
      a = t[0];
      b = t[1];
      c = t[2];
      if (it.operation == OpEnc) begin
        j = i * 6;
        t[0] = rotl((a ^ expanded_keys[j]) + (b ^ expanded_keys[j+1]), 9);
        t[1] = rotl((b ^ expanded_keys[j+2]) + (c ^ expanded_keys[j+3]), 27);
        t[2] = rotl((c ^ expanded_keys[j+4]) + (t[3] ^ expanded_keys[j+5]), 29);
        t[3] = a;
      end else begin
        j = (nr - 1 - i) * 6;
        t[0] = t[3];
        t[1] = (rotl(a, 23) - (t[0] ^ expanded_keys[j])) ^ expanded_keys[j+1];
        t[2] = (rotl(b, 5) - (t[1] ^ expanded_keys[j+2])) ^ expanded_keys[j+3];
        t[3] = (rotl(c, 3) - (t[2] ^ expanded_keys[j+4])) ^ expanded_keys[j+5];
      end
    end
    res.out_word_0 = swap_bytes(t[0]);
    res.out_word_1 = swap_bytes(t[1]);
    res.out_word_2 = swap_bytes(t[2]);
    res.out_word_3 = swap_bytes(t[3]);
  endtask

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // transfer monitor: predict on input, compare on output
  always @(posedge clk_i) begin
    out_t exp_blk;
    out_t got;
    if (rst_ni && in_valid_i && in_ready_o) begin
      cipher_block(in_data_i, exp_blk);
      pending_blocks.push_back(exp_blk);
      blocks_in++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      blocks_out++;
      if (pending_blocks.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        exp_blk = pending_blocks.pop_front();
        if (got.out_word_0 !== exp_blk.out_word_0)
          report($sformatf("out_word_0 %h exp %h", got.out_word_0, exp_blk.out_word_0));
        if (got.out_word_1 !== exp_blk.out_word_1)
          report($sformatf("out_word_1 %h exp %h", got.out_word_1, exp_blk.out_word_1));
        if (got.out_word_2 !== exp_blk.out_word_2)
          report($sformatf("out_word_2 %h exp %h", got.out_word_2, exp_blk.out_word_2));
        if (got.out_word_3 !== exp_blk.out_word_3)
          report($sformatf("out_word_3 %h exp %h", got.out_word_3, exp_blk.out_word_3));
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 35);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      RegKey01:  key_reg[0] = val;
      RegKey23:  key_reg[1] = val;
      RegKey45:  key_reg[2] = val;
      RegKey67:  key_reg[3] = val;
      RegKeyLen: key_len = val[1:0];
      default:   ;
    endcase
    if (idx <= RegKeyLen) sched_done = 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_key(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [1:0] len, input bit stray);
    write_reg(RegKey01, k0);
    write_reg(RegKey23, k1);
    write_reg(RegKey45, k2);
    write_reg(RegKey67, k3);
    write_reg(RegKeyLen, {62'd0, len});
    // writes past the register list must leave the key untouched
    if (stray) write_reg(RegKeyLen + 3'($urandom_range(1, 3)), {$urandom, $urandom});
    cfg_we_i <= 1'b0;
  endtask

  // sender: random gaps, then hold the block until it is taken
  task automatic send_block(input in_t it);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (MaxRounds + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      2:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_key(input int unsigned kind);
    case (kind)
      0:       return 64'h0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // directed blocks, sent with the reset key
  in_t directed [] = '{
    '{OpEnc, 32'h0, 32'h0, 32'h0, 32'h0},
    '{OpDec, 32'h0, 32'h0, 32'h0, 32'h0},
    '{OpEnc, '1, '1, '1, '1},
    '{OpDec, '1, '1, '1, '1},
    '{OpEnc, 32'h10111213, 32'h14151617, 32'h18191a1b, 32'h1c1d1e1f},
    '{OpDec, 32'h354ec89f, 32'h18c6c628, 32'ha7c73255, 32'hfd8b6404},
    '{OpEnc, 32'h80000000, 32'h0, 32'h0, 32'h1},
    '{OpEnc, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555},
    '{OpDec, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa},
    '{OpEnc, 32'h000000ff, 32'h0000ff00, 32'h00ff0000, 32'hff000000},
    '{OpDec, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210},
    '{OpEnc, 32'h7fffffff, 32'hfffffffe, 32'h0, 32'hffffffff}
  };

  initial begin
    logic [1:0]  lens [NumPhases] = '{Mode128, Mode192, Mode256, ModeSat,
                                      Mode256, Mode192, Mode128, ModeSat};
    int unsigned kinds [NumPhases] = '{2, 1, 0, 2, 1, 2, 0, 2};
    in_t         it;
    for (int k = 0; k < 4; k++) key_reg[k] = '0;
    key_len = Mode128;
    sched_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with the reset key
    foreach (directed[i]) send_block(directed[i]);
    drain();

    // random phases over all key sizes and key extremes
    for (int p = 0; p < NumPhases; p++) begin
      program_key(pick_key(kinds[p]), pick_key(kinds[p]), pick_key(kinds[p]),
                  pick_key(kinds[p]), lens[p], (p % 2) == 1);
      calm = (p == 2);
      for (int n = 0; n < PhaseLen; n++) begin
        // long receiver hold-off while the sender keeps offering blocks
        if (p == 1 && n == 10) hold_req = 300;
        it.operation    = $urandom_range(1);
        it.block_word_0 = pick_word();
        it.block_word_1 = pick_word();
        it.block_word_2 = pick_word();
        it.block_word_3 = pick_word();
        send_block(it);
      end
      calm = 1'b0;
      drain();
    end

    $display("covered %0d blocks in, %0d out, over %0d key settings", blocks_in,
             blocks_out, NumPhases + 1);
    $display("key sizes 128/192/256 and saturated length, encrypt and decrypt, stalls");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
